/* rtl/core/ucd_pkg.sv */
// Shared types, constants and the month table for the Unix time to calendar converter.
package ucd_pkg;

  // Reciprocal for seconds / 86400, applied as ((secs >> 7) * DAY_RECIP) >> 35.
  localparam logic [25:0] DAY_RECIP   = 26'd50903317;
  localparam logic [16:0] SECS_PER_DAY = 17'd86400;

  // Reciprocal for tod / 3600, applied as ((tod >> 4) * HOUR_RECIP) >> 21.
  localparam logic [13:0] HOUR_RECIP  = 14'd9321;
  localparam logic [11:0] SECS_PER_HOUR = 12'd3600;

  // Reciprocal for rem / 60, applied as ((rem >> 2) * MIN_RECIP) >> 14.
  localparam logic [10:0] MIN_RECIP   = 11'd1093;
  localparam logic [5:0]  SECS_PER_MIN = 6'd60;

  // Day count shifted so that day zero is 1600-03-01 (start of a 400-year era).
  localparam logic [17:0] ERA_SHIFT   = 18'd135080;
  localparam logic [17:0] DAYS_PER_ERA = 18'd146097;
  localparam logic [17:0] DAYS_PER_CENT = 18'd36524;
  localparam logic [17:0] ERA_LAST_DAY = 18'd146096;

  // doe / 1460 as ((doe >> 2) * QUAD_RECIP) >> 25.
  localparam logic [16:0] QUAD_RECIP  = 17'd91930;
  // t / 365 as (t * YEAR_RECIP) >> 27.
  localparam logic [18:0] YEAR_RECIP  = 19'd367720;
  localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
  // (5 * doy + 2) / 153 as (x * MONTH_RECIP) >> 19.
  localparam logic [11:0] MONTH_RECIP = 12'd3427;

  localparam logic [11:0] ERA_BASE_YEAR = 12'd1600;
  localparam logic [11:0] YEARS_PER_ERA = 12'd400;

  // Register stages inside each of the two datapath units.
  localparam int unsigned UNIT_STAGES = 7;

  typedef struct packed {
    logic [4:0] hour_of_day;
    logic [5:0] minute_of_hour;
    logic [5:0] second_of_minute;
  } hms_t;

  typedef struct packed {
    logic [4:0]  day_of_month;
    logic [3:0]  month_number;
    logic [11:0] year_number;
  } date_t;

  // First day of each month in a year that starts on March 1.
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] r;
    unique case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/core/ucd_stamp_if.sv */
// Valid/ready channel that carries one Unix timestamp per beat.
interface ucd_stamp_if;
  logic        valid;
  logic        ready;
  logic [31:0] unix_seconds;

  modport source (output valid, unix_seconds, input ready);
  modport sink (input valid, unix_seconds, output ready);
endinterface

/* rtl/core/ucd_date_if.sv */
// Valid/ready channel that carries one UTC date and time of day per beat.
interface ucd_date_if;
  logic        valid;
  logic        ready;
  logic [4:0]  day_of_month;
  logic [3:0]  month_number;
  logic [11:0] year_number;
  logic [4:0]  hour_of_day;
  logic [5:0]  minute_of_hour;
  logic [5:0]  second_of_minute;

  modport source (
    output valid, day_of_month, month_number, year_number,
           hour_of_day, minute_of_hour, second_of_minute,
    input  ready
  );
  modport sink (
    input  valid, day_of_month, month_number, year_number,
           hour_of_day, minute_of_hour, second_of_minute,
    output ready
  );
endinterface

/* rtl/core/unix_seconds_to_calendar_date.sv */
// Top level: Unix timestamp in seconds to UTC calendar date and time of day.
//
//   Port    Direction  Beat contents
//   stamp   in         unix_seconds (32 bits, unsigned)
//   date    out        day_of_month, month_number, year_number,
//                      hour_of_day, minute_of_hour, second_of_minute
//
// One beat is accepted per cycle while the output is not held; each result
// passes through 3 stages for the day split and 7 in the date and time units.
// Reset clears only the valid bits of the pipeline.
// When the output beat is held, the whole pipeline holds and stamp.ready is low.
module unix_seconds_to_calendar_date
  import ucd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  ucd_stamp_if.sink           stamp,
  ucd_date_if.source          date
);

  localparam int unsigned DEPTH = 3 + UNIT_STAGES;

  logic              adv;
  logic [DEPTH-1:0]  vld;
  logic [31:0]       secs_a;
  logic [50:0]       prod_b;
  logic [16:0]       secs_b;
  logic [15:0]       days_c;
  logic [16:0]       tod_c;

  logic [15:0]       days_w;
  logic [32:0]       day_secs;
  hms_t              hms;
  date_t             cal;

  assign adv         = !date.valid || date.ready;
  assign stamp.ready = adv;

  always_comb begin
    days_w   = prod_b[50:35];
    day_secs = 33'(days_w) * 33'(SECS_PER_DAY);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DEPTH-2:0], stamp.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      secs_a <= stamp.unix_seconds;
      prod_b <= 51'(secs_a[31:7]) * 51'(DAY_RECIP);
      secs_b <= secs_a[16:0];
      days_c <= days_w;
      tod_c  <= secs_b - day_secs[16:0];
    end
  end

  ucd_civil u_civil (
    .clk  (clk),
    .en   (adv),
    .days (days_c),
    .date (cal)
  );

  ucd_hms u_hms (
    .clk (clk),
    .en  (adv),
    .tod (tod_c),
    .hms (hms)
  );

  assign date.valid            = vld[DEPTH-1];
  assign date.day_of_month     = cal.day_of_month;
  assign date.month_number     = cal.month_number;
  assign date.year_number      = cal.year_number;
  assign date.hour_of_day      = hms.hour_of_day;
  assign date.minute_of_hour   = hms.minute_of_hour;
  assign date.second_of_minute = hms.second_of_minute;

endmodule

/* rtl/core/ucd_hms.sv */
// Pipelined split of the second within a day into hour, minute and second.
module ucd_hms
  import ucd_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [16:0] tod,
  output hms_t        hms
);

  localparam int unsigned DELAY = UNIT_STAGES - 4;

  logic [26:0] ph1;
  logic [16:0] tod1;
  logic [4:0]  hour2;
  logic [11:0] rem2;
  logic [20:0] pm3;
  logic [4:0]  hour3;
  logic [11:0] rem3;
  hms_t        hms4;
  hms_t        dly [DELAY];

  logic [4:0]  hour_w;
  logic [16:0] hour_secs;
  logic [5:0]  minute_w;
  logic [11:0] minute_secs;

  always_comb begin
    hour_w      = ph1[25:21];
    hour_secs   = 17'(hour_w) * 17'(SECS_PER_HOUR);
    minute_w    = pm3[19:14];
    minute_secs = 12'(minute_w) * 12'(SECS_PER_MIN);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ph1   <= 27'(tod[16:4]) * 27'(HOUR_RECIP);
      tod1  <= tod;
      hour2 <= hour_w;
      rem2  <= tod1[11:0] - hour_secs[11:0];
      pm3   <= 21'(rem2[11:2]) * 21'(MIN_RECIP);
      hour3 <= hour2;
      rem3  <= rem2;
      hms4.hour_of_day      <= hour3;
      hms4.minute_of_hour   <= minute_w;
      hms4.second_of_minute <= rem3[5:0] - minute_secs[5:0];
      dly[0] <= hms4;
      for (int i = 1; i < DELAY; i++) begin
        dly[i] <= dly[i-1];
      end
    end
  end

  assign hms = dly[DELAY-1];

endmodule

/* rtl/core/ucd_civil.sv */
// Pipelined conversion of a day count since 1970-01-01 to year, month and day.
module ucd_civil
  import ucd_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] days,
  output date_t       date
);

  // Stage 1: era and day of era.
  logic        era1;
  logic [17:0] doe1;
  // Stage 2: four-year and century counts.
  logic        era2;
  logic [17:0] doe2;
  logic [32:0] pq2;
  logic [2:0]  cent2;
  logic        last2;
  // Stage 3: day count with leap days removed.
  logic        era3;
  logic [17:0] doe3;
  logic [17:0] t3;
  // Stage 4: year of era product.
  logic        era4;
  logic [17:0] doe4;
  logic [35:0] py4;
  // Stage 5: day of the March-based year.
  logic        era5;
  logic [8:0]  yoe5;
  logic [8:0]  doy5;
  // Stage 6: month product.
  logic        era6;
  logic [8:0]  yoe6;
  logic [8:0]  doy6;
  logic [22:0] pm6;

  logic [17:0] z;
  logic        era_w;
  logic [17:0] doe_w;
  logic [2:0]  cent_w;
  logic [8:0]  yoe_w;
  logic [1:0]  ycent_w;
  logic [17:0] ystart_w;
  logic [10:0] mx_w;
  logic [3:0]  mp_w;
  logic [3:0]  month_w;
  logic [8:0]  dom_w;

  always_comb begin
    z      = 18'(days) + ERA_SHIFT;
    era_w  = (z >= DAYS_PER_ERA);
    doe_w  = era_w ? (z - DAYS_PER_ERA) : z;

    cent_w = 3'(doe1 >= DAYS_PER_CENT) + 3'(doe1 >= 18'(2 * DAYS_PER_CENT))
           + 3'(doe1 >= 18'(3 * DAYS_PER_CENT)) + 3'(doe1 >= 18'(4 * DAYS_PER_CENT));

    yoe_w    = py4[35:27];
    ycent_w  = 2'(yoe_w >= 9'd100) + 2'(yoe_w >= 9'd200) + 2'(yoe_w >= 9'd300);
    ystart_w = 18'(yoe_w) * 18'(DAYS_PER_YEAR) + 18'(yoe_w[8:2]) - 18'(ycent_w);

    mx_w    = 11'({doy5, 2'b00}) + 11'(doy5) + 11'd2;
    mp_w    = pm6[22:19];
    month_w = (mp_w < 4'd10) ? (mp_w + 4'd3) : (mp_w - 4'd9);
    dom_w   = doy6 - month_start(mp_w) + 9'd1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      era1  <= era_w;
      doe1  <= doe_w;

      era2  <= era1;
      doe2  <= doe1;
      pq2   <= 33'(doe1[17:2]) * 33'(QUAD_RECIP);
      cent2 <= cent_w;
      last2 <= (doe1 == ERA_LAST_DAY);

      era3  <= era2;
      doe3  <= doe2;
      t3    <= doe2 - 18'(pq2[32:25]) + 18'(cent2) - 18'(last2);

      era4  <= era3;
      doe4  <= doe3;
      py4   <= 36'(t3) * 36'(YEAR_RECIP);

      era5  <= era4;
      yoe5  <= yoe_w;
      doy5  <= 9'(doe4 - ystart_w);

      era6  <= era5;
      yoe6  <= yoe5;
      doy6  <= doy5;
      pm6   <= 23'(mx_w) * 23'(MONTH_RECIP);

      date.day_of_month <= dom_w[4:0];
      date.month_number <= month_w;
      // January and February belong to the next calendar year.
      date.year_number  <= ERA_BASE_YEAR + (era6 ? YEARS_PER_ERA : 12'd0)
                         + 12'(yoe6) + 12'(month_w <= 4'd2);
    end
  end

endmodule
